// File: design/piw_pkg.sv
package piw_pkg;

  localparam int POS_W      = 32;
  localparam int FORCE_W    = 48;
  localparam int MASS_W     = 24;
  localparam int TS_W       = 16;
  localparam int DAMP_W     = 17;
  localparam int LEN_W      = 31;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WALL_MARGIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_AREA_HEIGHT = 3'd5;

  localparam logic [TS_W-1:0]   TIME_STEP_RST   = 16'd1049;
  localparam logic [DAMP_W-1:0] DAMPING_RST     = 17'd64225;
  localparam logic [LEN_W-1:0]  MAX_SPEED_RST   = 31'd13107200;
  localparam logic [LEN_W-1:0]  WALL_MARGIN_RST = 31'd327680;
  localparam logic [LEN_W-1:0]  AREA_WIDTH_RST  = 31'd52428800;
  localparam logic [LEN_W-1:0]  AREA_HEIGHT_RST = 31'd39321600;

  // Restitution 0.4 and floor friction 0.8 in Q0.16.
  localparam logic [15:0] RESTITUTION = 16'd26214;
  localparam logic [15:0] FRICTION    = 16'd52429;

  // Quotient or root bits resolved per pipeline stage.
  localparam int FDIV_STEP_DEF = 4;
  localparam int VDIV_STEP_DEF = 2;
  localparam int SQRT_STEP_DEF = 2;

  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [POS_W-1:0] vel_x;
    logic [POS_W-1:0] vel_y;
  } piw_item_t;

  typedef struct packed {
    logic neg;
    logic ovf;
    logic zero;
  } piw_aflag_t;

  typedef struct packed {
    piw_item_t  item;
    piw_aflag_t fl;
  } piw_acc_side_t;

  // Velocity held as sign and magnitude after damping.
  typedef struct packed {
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             neg_x;
    logic [POS_W-1:0] mag_x;
    logic             neg_y;
    logic [POS_W-1:0] mag_y;
    logic             lim;
  } piw_vel_t;

endpackage

// File: design/piw_div.sv
module piw_div #(
  parameter int NUM_W  = 64,
  parameter int DEN_W  = 24,
  parameter int Q_W    = 48,
  parameter int STEP_N = 4,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [Q_W-1:0]    out_quot,
  output logic [SIDE_W-1:0] out_side
);

  // Restoring division, STEP_N quotient bits per stage. The upper
  // NUM_W-Q_W bits of the numerator must be below the denominator.
  localparam int NST   = Q_W / STEP_N;
  localparam int TOP_W = NUM_W - Q_W;

  logic              vld_r  [NST];
  logic [DEN_W-1:0]  rem_r  [NST];
  logic [Q_W-1:0]    work_r [NST];
  logic [DEN_W-1:0]  den_r  [NST];
  logic [SIDE_W-1:0] side_r [NST];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic              vld_in;
    logic [DEN_W-1:0]  rem_in;
    logic [Q_W-1:0]    work_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W-1:0]  rem_nxt;
    logic [Q_W-1:0]    work_nxt;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = DEN_W'(in_num[NUM_W-1 -: TOP_W]);
      assign work_in = in_num[Q_W-1:0];
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_rest
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign work_in = work_r[k-1];
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin : step
      logic [DEN_W:0] trial;
      rem_nxt  = rem_in;
      work_nxt = work_in;
      for (int i = 0; i < STEP_N; i++) begin
        trial    = {rem_nxt, work_nxt[Q_W-1]};
        work_nxt = {work_nxt[Q_W-2:0], 1'b0};
        if (trial >= {1'b0, den_in}) begin
          rem_nxt     = DEN_W'(trial - {1'b0, den_in});
          work_nxt[0] = 1'b1;
        end else begin
          rem_nxt = trial[DEN_W-1:0];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      work_r[k] <= work_nxt;
      den_r[k]  <= den_in;
      side_r[k] <= side_in;
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_quot  = work_r[NST-1];
  assign out_side  = side_r[NST-1];

endmodule

// File: design/piw_sqrt.sv
module piw_sqrt #(
  parameter int ROOT_W = 32,
  parameter int STEP_N = 2,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [2*ROOT_W-1:0] in_rad,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic [ROOT_W-1:0]   out_root,
  output logic [SIDE_W-1:0]   out_side
);

  // Digit-by-digit integer square root, STEP_N root bits per stage.
  localparam int NST   = ROOT_W / STEP_N;
  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;

  logic              vld_r  [NST];
  logic [REM_W-1:0]  rem_r  [NST];
  logic [ROOT_W-1:0] root_r [NST];
  logic [RAD_W-1:0]  rad_r  [NST];
  logic [SIDE_W-1:0] side_r [NST];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic              vld_in;
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    logic [SIDE_W-1:0] side_in;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;
    logic [RAD_W-1:0]  rad_nxt;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_rad;
      assign side_in = in_side;
    end else begin : g_rest
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign side_in = side_r[k-1];
    end

    always_comb begin : step
      logic [REM_W+1:0] temp;
      logic [REM_W+1:0] trial;
      rem_nxt  = rem_in;
      root_nxt = root_in;
      rad_nxt  = rad_in;
      for (int i = 0; i < STEP_N; i++) begin
        temp    = {rem_nxt, rad_nxt[RAD_W-1 -: 2]};
        rad_nxt = {rad_nxt[RAD_W-3:0], 2'b00};
        trial   = {2'b00, root_nxt, 2'b01};
        if (temp >= trial) begin
          rem_nxt  = REM_W'(temp - trial);
          root_nxt = {root_nxt[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = temp[REM_W-1:0];
          root_nxt = {root_nxt[ROOT_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      root_r[k] <= root_nxt;
      rad_r[k]  <= rad_nxt;
      side_r[k] <= side_in;
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_root  = root_r[NST-1];
  assign out_side  = side_r[NST-1];

endmodule

// File: design/particle_integrate_wall_bounce.sv
// Channel    | Ports                                         | Transfer when
// -----------+-----------------------------------------------+------------------------------
// input      | start, busy, in_pos_*, in_vel_*, in_force_*,  | start high and busy low
//            | in_mass                                       |
// result     | out_valid, out_pos_*, out_vel_*               | out_valid high (one cycle)
// config     | cfg_we, cfg_index, cfg_data                   | cfg_we high
//
// One particle enters per clock and its result leaves after the stage 0 capture
// register, the force divider pipeline, stages 1 to 8, the square root pipeline,
// stage 9, the speed-limit divider pipeline, stages 10 to 14 and the result
// registers. Throughput is one item per clock.
// Reset is synchronous and active low; it empties the pipeline and loads the
// register defaults, and busy is high only while reset is held.
// Nothing stalls: the receiver takes every result in the cycle it appears.
module particle_integrate_wall_bounce #(
  parameter int FDIV_STEP = piw_pkg::FDIV_STEP_DEF,
  parameter int SQRT_STEP = piw_pkg::SQRT_STEP_DEF,
  parameter int VDIV_STEP = piw_pkg::VDIV_STEP_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [piw_pkg::POS_W-1:0]      in_pos_x,
  input  logic signed [piw_pkg::POS_W-1:0]      in_pos_y,
  input  logic signed [piw_pkg::POS_W-1:0]      in_vel_x,
  input  logic signed [piw_pkg::POS_W-1:0]      in_vel_y,
  input  logic signed [piw_pkg::FORCE_W-1:0]    in_force_x,
  input  logic signed [piw_pkg::FORCE_W-1:0]    in_force_y,
  input  logic        [piw_pkg::MASS_W-1:0]     in_mass,
  output logic                                  out_valid,
  output logic signed [piw_pkg::POS_W-1:0]      out_pos_x,
  output logic signed [piw_pkg::POS_W-1:0]      out_pos_y,
  output logic signed [piw_pkg::POS_W-1:0]      out_vel_x,
  output logic signed [piw_pkg::POS_W-1:0]      out_vel_y,
  input  logic                                  cfg_we,
  input  logic        [piw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [piw_pkg::CFG_DATA_W-1:0] cfg_data
);

  import piw_pkg::*;

  localparam int FQ_W    = 48;
  localparam int ROOT_W  = 32;
  localparam int VQ_W    = 32;
  localparam int LATENCY = 1 + FQ_W / FDIV_STEP + 8 + ROOT_W / SQRT_STEP + 1
                           + VQ_W / VDIV_STEP + 6;

  // Saturate a 49-bit two's complement sum to 32 bits.
  function automatic logic [31:0] sat32(input logic [48:0] a);
    if ((&a[48:31]) || !(|a[48:31])) begin
      return a[31:0];
    end
    return a[48] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? 32'(~v + 32'd1) : v;
  endfunction

  function automatic logic [31:0] apply_sign(input logic neg, input logic [31:0] m);
    return neg ? 32'(~m + 32'd1) : m;
  endfunction

  // The input channel is open whenever reset is released.
  assign busy = ~rst_n;

  // ---------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------
  logic [TS_W-1:0]   time_step_r;
  logic [DAMP_W-1:0] damping_r;
  logic [LEN_W-1:0]  max_speed_r;
  logic [LEN_W-1:0]  wall_margin_r;
  logic [LEN_W-1:0]  area_width_r;
  logic [LEN_W-1:0]  area_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r   <= TIME_STEP_RST;
      damping_r     <= DAMPING_RST;
      max_speed_r   <= MAX_SPEED_RST;
      wall_margin_r <= WALL_MARGIN_RST;
      area_width_r  <= AREA_WIDTH_RST;
      area_height_r <= AREA_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIME_STEP:   time_step_r   <= cfg_data[TS_W-1:0];
        CFG_DAMPING:     damping_r     <= cfg_data[DAMP_W-1:0];
        CFG_MAX_SPEED:   max_speed_r   <= cfg_data[LEN_W-1:0];
        CFG_WALL_MARGIN: wall_margin_r <= cfg_data[LEN_W-1:0];
        CFG_AREA_WIDTH:  area_width_r  <= cfg_data[LEN_W-1:0];
        CFG_AREA_HEIGHT: area_height_r <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Stage 0: capture the input transfer.
  // ---------------------------------------------------------------------
  logic                s0_v_r;
  piw_item_t           s0_item_r;
  logic [FORCE_W-1:0]  s0_fx_r;
  logic [FORCE_W-1:0]  s0_fy_r;
  logic [MASS_W-1:0]   s0_mass_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else begin
      s0_v_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_item_r <= '{pos_x: in_pos_x, pos_y: in_pos_y, vel_x: in_vel_x, vel_y: in_vel_y};
    s0_fx_r   <= in_force_x;
    s0_fy_r   <= in_force_y;
    s0_mass_r <= in_mass;
  end

  // Acceleration is |force| << 16 divided by mass. When the upper force bits
  // already reach the mass, the quotient overflows and saturates instead.
  logic [FORCE_W-1:0] mag_fx;
  logic [FORCE_W-1:0] mag_fy;
  piw_aflag_t         flag_x;
  piw_aflag_t         flag_y;
  piw_acc_side_t      d1x_side_in;

  always_comb begin
    mag_fx      = s0_fx_r[FORCE_W-1] ? FORCE_W'(~s0_fx_r + 1'b1) : s0_fx_r;
    mag_fy      = s0_fy_r[FORCE_W-1] ? FORCE_W'(~s0_fy_r + 1'b1) : s0_fy_r;
    flag_x.neg  = s0_fx_r[FORCE_W-1];
    flag_x.ovf  = {8'd0, mag_fx[47:32]} >= s0_mass_r;
    flag_x.zero = s0_mass_r == '0;
    flag_y.neg  = s0_fy_r[FORCE_W-1];
    flag_y.ovf  = {8'd0, mag_fy[47:32]} >= s0_mass_r;
    flag_y.zero = s0_mass_r == '0;
    d1x_side_in = '{item: s0_item_r, fl: flag_x};
  end

  logic          d1x_valid;
  logic          d1y_valid;
  logic [FQ_W-1:0] d1x_quot;
  logic [FQ_W-1:0] d1y_quot;
  piw_acc_side_t d1x_side;
  piw_aflag_t    d1y_side;

  piw_div #(
    .NUM_W (64), .DEN_W (MASS_W), .Q_W (FQ_W), .STEP_N (FDIV_STEP),
    .SIDE_W ($bits(piw_acc_side_t))
  ) u_div_ax (
    .clk (clk), .rst_n (rst_n), .in_valid (s0_v_r),
    .in_num ({mag_fx, 16'd0}), .in_den (s0_mass_r), .in_side (d1x_side_in),
    .out_valid (d1x_valid), .out_quot (d1x_quot), .out_side (d1x_side)
  );

  piw_div #(
    .NUM_W (64), .DEN_W (MASS_W), .Q_W (FQ_W), .STEP_N (FDIV_STEP),
    .SIDE_W ($bits(piw_aflag_t))
  ) u_div_ay (
    .clk (clk), .rst_n (rst_n), .in_valid (s0_v_r),
    .in_num ({mag_fy, 16'd0}), .in_den (s0_mass_r), .in_side (flag_y),
    .out_valid (d1y_valid), .out_quot (d1y_quot), .out_side (d1y_side)
  );

  // ---------------------------------------------------------------------
  // Stage 1: saturate acceleration to the signed 48-bit range.
  // ---------------------------------------------------------------------
  logic            s1_v_r;
  piw_item_t       s1_item_r;
  logic [FQ_W-1:0] s1_max_r, s1_may_r;
  logic            s1_nx_r, s1_ny_r;
  logic [FQ_W-1:0] max_nxt, may_nxt, lim_ax, lim_ay;

  always_comb begin
    lim_ax = d1x_side.fl.neg ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    lim_ay = d1y_side.neg    ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
    if (d1x_side.fl.zero) begin
      max_nxt = '0;
    end else if (d1x_side.fl.ovf || d1x_quot > lim_ax) begin
      max_nxt = lim_ax;
    end else begin
      max_nxt = d1x_quot;
    end
    if (d1y_side.zero) begin
      may_nxt = '0;
    end else if (d1y_side.ovf || d1y_quot > lim_ay) begin
      may_nxt = lim_ay;
    end else begin
      may_nxt = d1y_quot;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: acceleration times time step.
  // Stage 3: kick the velocity, saturate to 32 bits.
  // Stage 4: damping product on the magnitude.
  // Stage 5: saturate the damped velocity.
  // ---------------------------------------------------------------------
  logic        s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  piw_item_t   s2_item_r, s3_item_r, s4_item_r;
  logic        s2_nx_r, s2_ny_r;
  logic [46:0] s2_kx_r, s2_ky_r;
  logic [63:0] kick_px, kick_py;
  logic [48:0] sum_vx, sum_vy;
  logic [48:0] damp_px, damp_py;
  logic        s4_nx_r, s4_ny_r;
  logic [32:0] s4_dx_r, s4_dy_r;
  logic [32:0] dlim_x, dlim_y, dsat_x, dsat_y;
  piw_vel_t    s5_vel_r;

  always_comb begin
    kick_px = s1_max_r * time_step_r;
    kick_py = s1_may_r * time_step_r;
    sum_vx  = {{17{s2_item_r.vel_x[31]}}, s2_item_r.vel_x}
              + (s2_nx_r ? 49'(~{2'b00, s2_kx_r} + 49'd1) : {2'b00, s2_kx_r});
    sum_vy  = {{17{s2_item_r.vel_y[31]}}, s2_item_r.vel_y}
              + (s2_ny_r ? 49'(~{2'b00, s2_ky_r} + 49'd1) : {2'b00, s2_ky_r});
    damp_px = abs32(s3_item_r.vel_x) * damping_r;
    damp_py = abs32(s3_item_r.vel_y) * damping_r;
    dlim_x  = s4_nx_r ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    dlim_y  = s4_ny_r ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
    dsat_x  = (s4_dx_r > dlim_x) ? dlim_x : s4_dx_r;
    dsat_y  = (s4_dy_r > dlim_y) ? dlim_y : s4_dy_r;
  end

  // ---------------------------------------------------------------------
  // Stages 6 to 8: squared speed against the squared limit.
  // ---------------------------------------------------------------------
  logic        s6_v_r, s7_v_r, s8_v_r;
  piw_vel_t    s6_vel_r, s7_vel_r, s8_vel_r;
  logic [63:0] s6_sqx_r, s6_sqy_r, s7_sq_r, s8_sq_r;
  logic [61:0] s6_lim_r, s7_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      s8_v_r <= 1'b0;
    end else begin
      s1_v_r <= d1x_valid & d1y_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
      s7_v_r <= s6_v_r;
      s8_v_r <= s7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_item_r <= d1x_side.item;
    s1_max_r  <= max_nxt;
    s1_may_r  <= may_nxt;
    s1_nx_r   <= d1x_side.fl.neg;
    s1_ny_r   <= d1y_side.neg;

    s2_item_r <= s1_item_r;
    s2_kx_r   <= kick_px[62:16];
    s2_ky_r   <= kick_py[62:16];
    s2_nx_r   <= s1_nx_r;
    s2_ny_r   <= s1_ny_r;

    s3_item_r <= '{pos_x: s2_item_r.pos_x, pos_y: s2_item_r.pos_y,
                   vel_x: sat32(sum_vx), vel_y: sat32(sum_vy)};

    s4_item_r <= s3_item_r;
    s4_nx_r   <= s3_item_r.vel_x[31];
    s4_ny_r   <= s3_item_r.vel_y[31];
    s4_dx_r   <= damp_px[48:16];
    s4_dy_r   <= damp_py[48:16];

    s5_vel_r <= '{pos_x: s4_item_r.pos_x, pos_y: s4_item_r.pos_y,
                  neg_x: s4_nx_r, mag_x: dsat_x[31:0],
                  neg_y: s4_ny_r, mag_y: dsat_y[31:0], lim: 1'b0};

    s6_vel_r <= s5_vel_r;
    s6_sqx_r <= s5_vel_r.mag_x * s5_vel_r.mag_x;
    s6_sqy_r <= s5_vel_r.mag_y * s5_vel_r.mag_y;
    s6_lim_r <= max_speed_r * max_speed_r;

    s7_vel_r <= s6_vel_r;
    s7_sq_r  <= s6_sqx_r + s6_sqy_r;
    s7_lim_r <= s6_lim_r;

    s8_vel_r <= '{pos_x: s7_vel_r.pos_x, pos_y: s7_vel_r.pos_y,
                  neg_x: s7_vel_r.neg_x, mag_x: s7_vel_r.mag_x,
                  neg_y: s7_vel_r.neg_y, mag_y: s7_vel_r.mag_y,
                  lim: s7_sq_r > {2'b00, s7_lim_r}};
    s8_sq_r  <= s7_sq_r;
  end

  // ---------------------------------------------------------------------
  // Speed magnitude, then each component scaled by max_speed / magnitude.
  // ---------------------------------------------------------------------
  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  piw_vel_t          sq_side;

  piw_sqrt #(
    .ROOT_W (ROOT_W), .STEP_N (SQRT_STEP), .SIDE_W ($bits(piw_vel_t))
  ) u_sqrt (
    .clk (clk), .rst_n (rst_n), .in_valid (s8_v_r),
    .in_rad (s8_sq_r), .in_side (s8_vel_r),
    .out_valid (sq_valid), .out_root (sq_root), .out_side (sq_side)
  );

  logic              s9_v_r;
  piw_vel_t          s9_vel_r;
  logic [63:0]       s9_numx_r, s9_numy_r;
  logic [ROOT_W-1:0] s9_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_v_r <= 1'b0;
    end else begin
      s9_v_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    s9_vel_r  <= sq_side;
    s9_numx_r <= sq_side.mag_x * max_speed_r;
    s9_numy_r <= sq_side.mag_y * max_speed_r;
    s9_mag_r  <= sq_root;
  end

  logic            d2x_valid, d2y_valid;
  logic [VQ_W-1:0] d2x_quot, d2y_quot;
  piw_vel_t        d2x_side;
  logic [0:0]      d2y_side;

  piw_div #(
    .NUM_W (64), .DEN_W (ROOT_W), .Q_W (VQ_W), .STEP_N (VDIV_STEP),
    .SIDE_W ($bits(piw_vel_t))
  ) u_div_vx (
    .clk (clk), .rst_n (rst_n), .in_valid (s9_v_r),
    .in_num (s9_numx_r), .in_den (s9_mag_r), .in_side (s9_vel_r),
    .out_valid (d2x_valid), .out_quot (d2x_quot), .out_side (d2x_side)
  );

  piw_div #(
    .NUM_W (64), .DEN_W (ROOT_W), .Q_W (VQ_W), .STEP_N (VDIV_STEP), .SIDE_W (1)
  ) u_div_vy (
    .clk (clk), .rst_n (rst_n), .in_valid (s9_v_r),
    .in_num (s9_numy_r), .in_den (s9_mag_r), .in_side (s9_vel_r.neg_y),
    .out_valid (d2y_valid), .out_quot (d2y_quot), .out_side (d2y_side)
  );

  // ---------------------------------------------------------------------
  // Stage 10: pick limited or plain velocity.
  // Stage 11: velocity times time step.
  // Stage 12: advance the position, saturate to 32 bits.
  // ---------------------------------------------------------------------
  logic        s10_v_r, s11_v_r, s12_v_r;
  piw_vel_t    s10_vel_r, s11_vel_r, s12_vel_r;
  logic [47:0] step_px, step_py;
  logic [31:0] s11_kx_r, s11_ky_r;
  logic [48:0] sum_px, sum_py;

  always_comb begin
    step_px = s10_vel_r.mag_x * time_step_r;
    step_py = s10_vel_r.mag_y * time_step_r;
    sum_px  = {{17{s11_vel_r.pos_x[31]}}, s11_vel_r.pos_x}
              + (s11_vel_r.neg_x ? 49'(~{17'd0, s11_kx_r} + 49'd1) : {17'd0, s11_kx_r});
    sum_py  = {{17{s11_vel_r.pos_y[31]}}, s11_vel_r.pos_y}
              + (s11_vel_r.neg_y ? 49'(~{17'd0, s11_ky_r} + 49'd1) : {17'd0, s11_ky_r});
  end

  // ---------------------------------------------------------------------
  // Stage 13: wall tests. Left then right share the x axis, floor then
  // ceiling the y axis; a later wall on the same axis wins its clamp.
  // ---------------------------------------------------------------------
  logic [32:0] margin33, right33, top33;
  logic [32:0] px33, py33, pxl, pyl;
  logic        hit_l, hit_r, hit_f, hit_c;
  logic [31:0] wall_px, wall_py;
  logic [47:0] rest_px, rest_py;

  always_comb begin
    margin33 = {2'b00, wall_margin_r};
    right33  = {2'b00, area_width_r} - margin33;
    top33    = {2'b00, area_height_r} - margin33;
    px33     = {s12_vel_r.pos_x[31], s12_vel_r.pos_x};
    py33     = {s12_vel_r.pos_y[31], s12_vel_r.pos_y};
    hit_l    = $signed(px33) < $signed(margin33);
    pxl      = hit_l ? margin33 : px33;
    hit_r    = $signed(pxl) > $signed(right33);
    wall_px  = hit_r ? right33[31:0] : pxl[31:0];
    hit_f    = $signed(py33) < $signed(margin33);
    pyl      = hit_f ? margin33 : py33;
    hit_c    = $signed(pyl) > $signed(top33);
    wall_py  = hit_c ? top33[31:0] : pyl[31:0];
    rest_px  = s12_vel_r.mag_x * RESTITUTION;
    rest_py  = s12_vel_r.mag_y * RESTITUTION;
  end

  logic        s13_v_r, s14_v_r;
  piw_vel_t    s13_vel_r, s14_vel_r;
  logic        s13_l_r, s13_r_r, s13_f_r, s13_c_r, s14_f_r;
  logic [31:0] s13_r1x_r, s13_r1y_r;

  // ---------------------------------------------------------------------
  // Stage 14: reflected velocities. Hitting both walls of an axis applies
  // restitution twice; the floor halves its bounce before the ceiling sees it.
  // ---------------------------------------------------------------------
  logic [31:0] half_y;
  logic [47:0] rest2_px, rest2_py;
  piw_vel_t    refl_vel;

  always_comb begin
    half_y   = {1'b0, s13_r1y_r[31:1]};
    rest2_px = s13_r1x_r * RESTITUTION;
    rest2_py = half_y * RESTITUTION;
    refl_vel = s13_vel_r;
    case ({s13_l_r, s13_r_r})
      2'b10: begin
        refl_vel.neg_x = 1'b0;
        refl_vel.mag_x = s13_r1x_r;
      end
      2'b01: begin
        refl_vel.neg_x = 1'b1;
        refl_vel.mag_x = s13_r1x_r;
      end
      2'b11: begin
        refl_vel.neg_x = 1'b1;
        refl_vel.mag_x = rest2_px[47:16];
      end
      default: ;
    endcase
    case ({s13_f_r, s13_c_r})
      2'b10: begin
        refl_vel.neg_y = 1'b0;
        refl_vel.mag_y = half_y;
      end
      2'b01: begin
        refl_vel.neg_y = 1'b1;
        refl_vel.mag_y = s13_r1y_r;
      end
      2'b11: begin
        refl_vel.neg_y = 1'b1;
        refl_vel.mag_y = rest2_py[47:16];
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Stage 15: floor friction on x and the result registers.
  // ---------------------------------------------------------------------
  logic [47:0] fric_p;
  logic [31:0] fin_mx;

  always_comb begin
    fric_p = s14_vel_r.mag_x * FRICTION;
    fin_mx = s14_f_r ? fric_p[47:16] : s14_vel_r.mag_x;
  end

  logic        out_valid_r;
  logic [31:0] out_pos_x_r, out_pos_y_r, out_vel_x_r, out_vel_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s10_v_r     <= 1'b0;
      s11_v_r     <= 1'b0;
      s12_v_r     <= 1'b0;
      s13_v_r     <= 1'b0;
      s14_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s10_v_r     <= d2x_valid & d2y_valid;
      s11_v_r     <= s10_v_r;
      s12_v_r     <= s11_v_r;
      s13_v_r     <= s12_v_r;
      s14_v_r     <= s13_v_r;
      out_valid_r <= s14_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s10_vel_r <= '{pos_x: d2x_side.pos_x, pos_y: d2x_side.pos_y,
                   neg_x: d2x_side.neg_x,
                   mag_x: d2x_side.lim ? d2x_quot : d2x_side.mag_x,
                   neg_y: d2y_side[0],
                   mag_y: d2x_side.lim ? d2y_quot : d2x_side.mag_y,
                   lim: d2x_side.lim};

    s11_vel_r <= s10_vel_r;
    s11_kx_r  <= step_px[47:16];
    s11_ky_r  <= step_py[47:16];

    s12_vel_r <= '{pos_x: sat32(sum_px), pos_y: sat32(sum_py),
                   neg_x: s11_vel_r.neg_x, mag_x: s11_vel_r.mag_x,
                   neg_y: s11_vel_r.neg_y, mag_y: s11_vel_r.mag_y,
                   lim: s11_vel_r.lim};

    s13_vel_r <= '{pos_x: wall_px, pos_y: wall_py,
                   neg_x: s12_vel_r.neg_x, mag_x: s12_vel_r.mag_x,
                   neg_y: s12_vel_r.neg_y, mag_y: s12_vel_r.mag_y,
                   lim: s12_vel_r.lim};
    s13_l_r   <= hit_l;
    s13_r_r   <= hit_r;
    s13_f_r   <= hit_f;
    s13_c_r   <= hit_c;
    s13_r1x_r <= rest_px[47:16];
    s13_r1y_r <= rest_py[47:16];

    s14_vel_r <= refl_vel;
    s14_f_r   <= s13_f_r;

    out_pos_x_r <= s14_vel_r.pos_x;
    out_pos_y_r <= s14_vel_r.pos_y;
    out_vel_x_r <= apply_sign(s14_vel_r.neg_x, fin_mx);
    out_vel_y_r <= apply_sign(s14_vel_r.neg_y, s14_vel_r.mag_y);
  end

  assign out_valid = out_valid_r;
  assign out_pos_x = out_pos_x_r;
  assign out_pos_y = out_pos_y_r;
  assign out_vel_x = out_vel_x_r;
  assign out_vel_y = out_vel_y_r;

  // Every result strobe traces back to exactly one input transfer.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching input transfer");

  // With a sane margin, the reported position lies between the x walls.
  a_inside_x: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($signed(margin33) <= $signed(right33))) |->
      (($signed({out_pos_x[31], out_pos_x}) >= $signed(margin33)) &&
       ($signed({out_pos_x[31], out_pos_x}) <= $signed(right33))))
    else $error("x position outside the walls");

  // Same for the floor and ceiling.
  a_inside_y: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($signed(margin33) <= $signed(top33))) |->
      (($signed({out_pos_y[31], out_pos_y}) >= $signed(margin33)) &&
       ($signed({out_pos_y[31], out_pos_y}) <= $signed(top33))))
    else $error("y position outside the walls");

endmodule
